@@ sv/window_median_select_defines.svh @@
// assertion helpers for the window median block
`ifndef WINDOW_MEDIAN_SELECT_DEFINES_SVH
`define WINDOW_MEDIAN_SELECT_DEFINES_SVH

// checked only while out of reset
`define WMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define WMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ sv/wms_pkg.sv @@
package wms_pkg;

    localparam int MAX_DIM = 7;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CNT_W   = $clog2(DEPTH);
    localparam int PIX_W   = 8;
    localparam int DIM_W   = 3;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [DIM_W-1:0] dim_t;

    localparam dim_t DIM_RESET = dim_t'(3);

    // commands from the controller to the sorting chain
    typedef struct packed {
        logic             insert;
        logic             clear;
        logic             load;
        logic [DEPTH-1:0] pick_sel;
    } wms_cmd_t;

endpackage

@@ sv/wms_ctrl.sv @@
module wms_ctrl import wms_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  dim_t     cfg_data,
    output logic     m_tvalid,
    input  logic     m_tready,
    output wms_cmd_t cmd
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_HOLD    = 1'b1;

    // index of the last byte of a window, side 0 counts as 1
    function automatic count_t last_index(dim_t dim);
        logic [2*DIM_W-1:0] side;
        logic [2*DIM_W-1:0] sq;
        side = {{DIM_W{1'b0}}, dim};
        if (dim == '0) begin
            side = {{(2*DIM_W-1){1'b0}}, 1'b1};
        end else if (dim > dim_t'(MAX_DIM)) begin
            side = (2*DIM_W)'(MAX_DIM);
        end
        sq = side * side;
        return count_t'(sq - 1'b1);
    endfunction

    function automatic logic [DEPTH-1:0] mid_onehot(count_t last);
        logic [DEPTH-1:0] sel;
        count_t           mid;
        mid = last >> 1;
        for (int i = 0; i < DEPTH; i++) begin
            sel[i] = (count_t'(i) == mid);
        end
        return sel;
    endfunction

    logic             state_reg, state_next;
    count_t           count_reg, count_next;
    count_t           last_reg, last_next;
    logic [DEPTH-1:0] sel_reg, sel_next;
    logic             window_last, accept, cfg_wr, done;

    assign cfg_ready   = 1'b1;
    assign cfg_wr      = cfg_valid;
    assign window_last = (count_reg == last_reg);
    // only the closing beat of a window needs room in the output register
    assign s_tready    = !window_last || (state_reg == ST_COLLECT) || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign done        = accept && window_last;
    assign m_tvalid    = (state_reg == ST_HOLD);

    assign cmd.insert   = accept;
    assign cmd.clear    = done || cfg_wr;
    assign cmd.load     = done;
    assign cmd.pick_sel = sel_reg;

    always_comb begin
        count_next = count_reg;
        last_next  = last_reg;
        sel_next   = sel_reg;
        if (cfg_wr) begin
            last_next  = last_index(cfg_data);
            sel_next   = mid_onehot(last_next);
            count_next = '0;
        end else if (accept) begin
            count_next = window_last ? '0 : count_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (done) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (!done && m_tready) state_next = ST_COLLECT;
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            count_reg <= '0;
            last_reg  <= last_index(DIM_RESET);
            sel_reg   <= mid_onehot(last_index(DIM_RESET));
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

@@ sv/wms_datapath.sv @@
module wms_datapath import wms_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  wms_cmd_t cmd,
    input  pixel_t   s_tdata,
    output pixel_t   m_tdata
);

    pixel_t           val_reg [DEPTH];
    pixel_t           val_next [DEPTH];
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic [DEPTH-1:0] gt;
    pixel_t           median_reg, median_pick;

    // empty cells sort above every byte
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = !vld_reg[i] || (val_reg[i] > s_tdata);
        end
    end

    // insertion: cells above the slot shift up by one
    always_comb begin
        val_next[0] = gt[0] ? s_tdata : val_reg[0];
        vld_next[0] = gt[0] ? 1'b1    : vld_reg[0];
        for (int i = 1; i < DEPTH; i++) begin
            val_next[i] = val_reg[i];
            vld_next[i] = vld_reg[i];
            if (gt[i]) begin
                if (!gt[i-1]) begin
                    val_next[i] = s_tdata;
                    vld_next[i] = 1'b1;
                end else begin
                    val_next[i] = val_reg[i-1];
                    vld_next[i] = vld_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        median_pick = '0;
        for (int i = 0; i < DEPTH; i++) begin
            median_pick = median_pick | (val_next[i] & {PIX_W{cmd.pick_sel[i]}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.clear) begin
            vld_reg <= '0;
        end else if (cmd.insert) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            for (int i = 0; i < DEPTH; i++) begin
                val_reg[i] <= val_next[i];
            end
        end
        if (cmd.load) begin
            median_reg <= median_pick;
        end
    end

    assign m_tdata = median_reg;

endmodule

@@ sv/window_median_select.sv @@
// channel   dir  handshake             payload
// s_        in   s_tvalid/s_tready     s_tdata: pixel [7:0]
// m_        out  m_tvalid/m_tready     m_tdata: median_value [7:0]
// cfg_      in   cfg_valid/cfg_ready   cfg_data: window_dim [2:0]
//
// one pixel beat per cycle while s_tready is high: the sorting chain places each byte as it is accepted
// the median leaves the output register in the cycle after the closing beat of a window
// input stalls only on the closing beat while an earlier median still waits
// a window_dim write discards any partial window; cfg_ready is always high
// synchronous active-low reset: empty chain, window_dim of 3
module window_median_select import wms_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  pixel_t s_tdata,   // [7:0] pixel
    output logic   m_tvalid,
    input  logic   m_tready,
    output pixel_t m_tdata,   // [7:0] median_value
    input  logic   cfg_valid,
    output logic   cfg_ready,
    input  dim_t   cfg_data
);

    wms_cmd_t cmd;

    wms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    wms_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

@@ sv/wms_checker.sv @@
`include "window_median_select_defines.svh"

module wms_checker import wms_pkg::*; (
    input logic   aclk,
    input logic   aresetn,
    input logic   s_tvalid,
    input logic   s_tready,
    input pixel_t s_tdata,
    input logic   m_tvalid,
    input logic   m_tready,
    input pixel_t m_tdata,
    input logic   cfg_valid,
    input logic   cfg_ready,
    input dim_t   cfg_data
);

    `WMS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "median beat dropped or changed while stalled")

    `WMS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result shown right after reset")

    `WMS_ASSERT(a_result_cause, $rose(m_tvalid) |-> $past(s_tvalid && s_tready), "result without an accepted pixel")

    `WMS_ASSERT(a_unit_window, cfg_valid && cfg_ready && (cfg_data == 3'd0 || cfg_data == 3'd1) ##1 s_tvalid && s_tready && !cfg_valid |=> m_tvalid && m_tdata == $past(s_tdata), "single pixel window not passed through")

endmodule

bind window_median_select wms_checker u_wms_checker (.*);
